// ===== rtl/core/qalu_pkg.sv =====
// Shared types, widths, operation codes and saturation helper of the quaternion unit.
// Used by quaternion_alu_unit and by its port checker; depends on nothing else.
package qalu_pkg;

    // Fixed-point format and datapath widths.
    localparam int FRAC_BITS = 16;
    localparam int QW        = 32;                 // one Q16.16 value
    localparam int LANES     = 4;                  // quaternion components
    localparam int CMD_W     = 4;
    localparam int PW        = 2 * QW;             // one exact product
    localparam int SW        = PW + 2;             // exact sum of four products
    localparam int SQ_STEPS  = SW / 2;             // square root digit steps
    localparam int RT_W      = SQ_STEPS;           // square root width
    localparam int SQ_REM_W  = RT_W + 2;           // square root remainder width
    localparam int DV_W      = QW + FRAC_BITS;     // scaled dividend width
    localparam int DEN_W     = QW + 1;             // divisor width (up to 2^32)

    // Stream payload layout.
    localparam int IN_W     = 2 * LANES * QW + QW;
    localparam int EQ_BIT   = 5 * QW;
    localparam int ERR_BIT  = 5 * QW + 1;
    localparam int OUT_PAD  = 6;
    localparam int OUT_W    = ERR_BIT + 1 + OUT_PAD;

    localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 4'd0,
        CMD_SUB       = 4'd1,
        CMD_MUL       = 4'd2,
        CMD_DIV       = 4'd3,
        CMD_SCALE     = 4'd4,
        CMD_SDIV      = 4'd5,
        CMD_CONJ      = 4'd6,
        CMD_NEG       = 4'd7,
        CMD_NORMALIZE = 4'd8,
        CMD_INVERSE   = 4'd9,
        CMD_DOT       = 4'd10,
        CMD_LENSQ     = 4'd11,
        CMD_LEN       = 4'd12,
        CMD_EQUAL     = 4'd13
    } cmd_e;

    typedef struct packed {
        logic [QW-1:0] val;
        logic          ovf;
    } sat_t;

    // Everything an item carries down the root and divider pipelines.
    typedef struct packed {
        cmd_e                      cmd;
        logic [LANES-1:0][QW-1:0]  r;       // final result when no divide
        logic [QW-1:0]             so;
        logic                      eq;
        logic                      err;
        logic                      use_div;
        logic [QW-1:0]             den;     // divisor magnitude, except normalize
        logic [LANES-1:0]          neg;     // quotient sign per lane
        logic [LANES-1:0][QW-1:0]  mag;     // numerator magnitude per lane
    } meta_t;

    // Clamp a wide signed value to 32 bits and flag the clamp.
    function automatic sat_t sat_q(input logic signed [SW-1:0] v);
        sat_t res;
        res.ovf = !((&v[SW-1:QW-1]) || !(|v[SW-1:QW-1]));
        if (res.ovf) begin
            res.val = v[SW-1] ? Q_MIN : Q_MAX;
        end else begin
            res.val = v[QW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/quaternion_alu_unit.sv =====
// Top level of the pipelined Q16.16 quaternion arithmetic unit.
// Depends on qalu_pkg for widths, operation codes, the payload struct and saturation.

// The unit takes one operation per clock cycle while the output is not stalled and
// returns one result per operation, in order. Every operation takes the same path:
// the product and sum registers, the setup register, the 33-stage square root
// pipeline, the divider entry register, the 48-stage quotient pipeline and the
// output register.
// A stall on the result side freezes the whole pipeline; nothing is dropped.
module quaternion_alu_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_in
    input  logic [qalu_pkg::IN_W-1:0]    s_tdata,
    // command
    input  logic [qalu_pkg::CMD_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // r_w, r_x, r_y, r_z, scalar_out, is_equal, error, zero padding
    output logic [qalu_pkg::OUT_W-1:0]   m_tdata
);
    import qalu_pkg::*;

    logic en;
    logic out_vld_reg;
    logic [OUT_W-1:0] out_data_reg;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Input field unpacking.
    logic signed [QW-1:0] in_a [LANES];
    logic signed [QW-1:0] in_b [LANES];
    logic signed [QW-1:0] in_s;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            in_a[i] = s_tdata[i*QW +: QW];
            in_b[i] = s_tdata[(LANES+i)*QW +: QW];
        end
        in_s = s_tdata[2*LANES*QW +: QW];
    end

    // Stage 1: every product the operations need.
    logic                 p1_vld_reg;
    cmd_e                 p1_cmd_reg;
    logic signed [QW-1:0] p1_a_reg [LANES];
    logic signed [QW-1:0] p1_b_reg [LANES];
    logic signed [QW-1:0] p1_s_reg;
    logic signed [PW-1:0] p1_ab_reg [LANES][LANES];
    logic signed [PW-1:0] p1_as_reg [LANES];
    logic [PW-1:0]        p1_aa_reg [LANES];
    logic [PW-1:0]        p1_bb_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_cmd_reg <= cmd_e'(s_tuser);
            p1_s_reg   <= in_s;
            for (int i = 0; i < LANES; i++) begin
                p1_a_reg[i]  <= in_a[i];
                p1_b_reg[i]  <= in_b[i];
                p1_as_reg[i] <= in_a[i] * in_s;
                p1_aa_reg[i] <= in_a[i] * in_a[i];
                p1_bb_reg[i] <= in_b[i] * in_b[i];
                for (int j = 0; j < LANES; j++) begin
                    p1_ab_reg[i][j] <= in_a[i] * in_b[j];
                end
            end
        end
    end

    // Stage 2: exact sums of products.
    logic                 p2_vld_reg;
    cmd_e                 p2_cmd_reg;
    logic signed [QW-1:0] p2_a_reg [LANES];
    logic signed [QW-1:0] p2_b_reg [LANES];
    logic signed [QW-1:0] p2_s_reg;
    logic signed [SW-1:0] p2_ham_reg [LANES];
    logic signed [SW-1:0] p2_hcb_reg [LANES];
    logic signed [SW-1:0] p2_dot_reg;
    logic signed [PW-1:0] p2_scl_reg [LANES];
    logic [SW-2:0]        p2_sa_reg;
    logic [SW-2:0]        p2_sb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (en) begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_cmd_reg <= p1_cmd_reg;
            p2_s_reg   <= p1_s_reg;
            p2_a_reg   <= p1_a_reg;
            p2_b_reg   <= p1_b_reg;
            p2_scl_reg <= p1_as_reg;
            // Hamilton product a * b.
            p2_ham_reg[0] <= SW'(p1_ab_reg[0][0]) - SW'(p1_ab_reg[1][1])
                           - SW'(p1_ab_reg[2][2]) - SW'(p1_ab_reg[3][3]);
            p2_ham_reg[1] <= SW'(p1_ab_reg[0][1]) + SW'(p1_ab_reg[1][0])
                           + SW'(p1_ab_reg[2][3]) - SW'(p1_ab_reg[3][2]);
            p2_ham_reg[2] <= SW'(p1_ab_reg[0][2]) + SW'(p1_ab_reg[2][0])
                           + SW'(p1_ab_reg[3][1]) - SW'(p1_ab_reg[1][3]);
            p2_ham_reg[3] <= SW'(p1_ab_reg[0][3]) + SW'(p1_ab_reg[3][0])
                           + SW'(p1_ab_reg[1][2]) - SW'(p1_ab_reg[2][1]);
            // Hamilton product a * conj(b), with the conjugate folded into the signs.
            p2_hcb_reg[0] <= SW'(p1_ab_reg[0][0]) + SW'(p1_ab_reg[1][1])
                           + SW'(p1_ab_reg[2][2]) + SW'(p1_ab_reg[3][3]);
            p2_hcb_reg[1] <= SW'(p1_ab_reg[1][0]) - SW'(p1_ab_reg[0][1])
                           + SW'(p1_ab_reg[3][2]) - SW'(p1_ab_reg[2][3]);
            p2_hcb_reg[2] <= SW'(p1_ab_reg[2][0]) - SW'(p1_ab_reg[0][2])
                           + SW'(p1_ab_reg[1][3]) - SW'(p1_ab_reg[3][1]);
            p2_hcb_reg[3] <= SW'(p1_ab_reg[3][0]) - SW'(p1_ab_reg[0][3])
                           + SW'(p1_ab_reg[2][1]) - SW'(p1_ab_reg[1][2]);
            p2_dot_reg <= SW'(p1_ab_reg[0][0]) + SW'(p1_ab_reg[1][1])
                        + SW'(p1_ab_reg[2][2]) + SW'(p1_ab_reg[3][3]);
            p2_sa_reg <= (SW-1)'(p1_aa_reg[0]) + (SW-1)'(p1_aa_reg[1])
                       + (SW-1)'(p1_aa_reg[2]) + (SW-1)'(p1_aa_reg[3]);
            p2_sb_reg <= (SW-1)'(p1_bb_reg[0]) + (SW-1)'(p1_bb_reg[1])
                       + (SW-1)'(p1_bb_reg[2]) + (SW-1)'(p1_bb_reg[3]);
        end
    end

    // Stage 3 logic: saturate, finish the simple operations, set up the divides.
    sat_t          add_s [LANES];
    sat_t          sub_s [LANES];
    sat_t          neg_s [LANES];
    sat_t          ham_s [LANES];
    sat_t          hcb_s [LANES];
    sat_t          scl_s [LANES];
    sat_t          dot_s;
    sat_t          lsa_s;
    sat_t          lsb_s;
    logic [QW-1:0] a_mag [LANES];
    logic [QW-1:0] p_mag [LANES];
    logic [QW-1:0] s_mag;
    logic          a_zero;
    meta_t         m3;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            add_s[i] = sat_q(SW'(p2_a_reg[i]) + SW'(p2_b_reg[i]));
            sub_s[i] = sat_q(SW'(p2_a_reg[i]) - SW'(p2_b_reg[i]));
            neg_s[i] = sat_q(-SW'(p2_a_reg[i]));
            ham_s[i] = sat_q(p2_ham_reg[i] >>> FRAC_BITS);
            hcb_s[i] = sat_q(p2_hcb_reg[i] >>> FRAC_BITS);
            scl_s[i] = sat_q(SW'(p2_scl_reg[i]) >>> FRAC_BITS);
            a_mag[i] = p2_a_reg[i][QW-1] ? (~p2_a_reg[i] + 1'b1) : p2_a_reg[i];
            p_mag[i] = hcb_s[i].val[QW-1] ? (~hcb_s[i].val + 1'b1) : hcb_s[i].val;
        end
        dot_s  = sat_q(p2_dot_reg >>> FRAC_BITS);
        lsa_s  = sat_q($signed({1'b0, p2_sa_reg}) >>> FRAC_BITS);
        lsb_s  = sat_q($signed({1'b0, p2_sb_reg}) >>> FRAC_BITS);
        s_mag  = p2_s_reg[QW-1] ? (~p2_s_reg + 1'b1) : p2_s_reg;
        a_zero = (p2_sa_reg == '0);
    end

    always_comb begin
        m3     = '0;
        m3.cmd = p2_cmd_reg;
        case (p2_cmd_reg)
            CMD_ADD: begin
                for (int i = 0; i < LANES; i++) begin
                    m3.r[i] = add_s[i].val;
                    m3.err  = m3.err | add_s[i].ovf;
                end
            end
            CMD_SUB: begin
                for (int i = 0; i < LANES; i++) begin
                    m3.r[i] = sub_s[i].val;
                    m3.err  = m3.err | sub_s[i].ovf;
                end
            end
            CMD_MUL: begin
                for (int i = 0; i < LANES; i++) begin
                    m3.r[i] = ham_s[i].val;
                    m3.err  = m3.err | ham_s[i].ovf;
                end
            end
            CMD_DIV: begin
                m3.use_div = 1'b1;
                m3.den     = lsb_s.val;
                m3.err     = lsb_s.ovf;
                for (int i = 0; i < LANES; i++) begin
                    m3.err    = m3.err | hcb_s[i].ovf;
                    m3.mag[i] = p_mag[i];
                    m3.neg[i] = hcb_s[i].val[QW-1];
                end
            end
            CMD_SCALE: begin
                for (int i = 0; i < LANES; i++) begin
                    m3.r[i] = scl_s[i].val;
                    m3.err  = m3.err | scl_s[i].ovf;
                end
            end
            CMD_SDIV: begin
                m3.use_div = 1'b1;
                m3.den     = s_mag;
                for (int i = 0; i < LANES; i++) begin
                    m3.mag[i] = a_mag[i];
                    m3.neg[i] = p2_a_reg[i][QW-1] ^ p2_s_reg[QW-1];
                end
            end
            CMD_CONJ: begin
                m3.r[0] = p2_a_reg[0];
                for (int i = 1; i < LANES; i++) begin
                    m3.r[i] = neg_s[i].val;
                    m3.err  = m3.err | neg_s[i].ovf;
                end
            end
            CMD_NEG: begin
                for (int i = 0; i < LANES; i++) begin
                    m3.r[i] = neg_s[i].val;
                    m3.err  = m3.err | neg_s[i].ovf;
                end
            end
            CMD_NORMALIZE: begin
                // A zero quaternion passes through; otherwise divide by the root.
                if (a_zero) begin
                    for (int i = 0; i < LANES; i++) begin
                        m3.r[i] = p2_a_reg[i];
                    end
                end else begin
                    m3.use_div = 1'b1;
                    for (int i = 0; i < LANES; i++) begin
                        m3.mag[i] = a_mag[i];
                        m3.neg[i] = p2_a_reg[i][QW-1];
                    end
                end
            end
            CMD_INVERSE: begin
                if (a_zero) begin
                    for (int i = 0; i < LANES; i++) begin
                        m3.r[i] = p2_a_reg[i];
                    end
                end else begin
                    m3.use_div = 1'b1;
                    m3.den     = lsa_s.val;
                    m3.err     = lsa_s.ovf;
                    m3.mag[0]  = a_mag[0];
                    m3.neg[0]  = p2_a_reg[0][QW-1];
                    for (int i = 1; i < LANES; i++) begin
                        m3.mag[i] = a_mag[i];
                        m3.neg[i] = !p2_a_reg[i][QW-1];
                    end
                end
            end
            CMD_DOT: begin
                m3.so  = dot_s.val;
                m3.err = dot_s.ovf;
            end
            CMD_LENSQ: begin
                m3.so  = lsa_s.val;
                m3.err = lsa_s.ovf;
            end
            CMD_EQUAL: begin
                m3.eq = (p2_a_reg[0] == p2_b_reg[0]) && (p2_a_reg[1] == p2_b_reg[1])
                     && (p2_a_reg[2] == p2_b_reg[2]) && (p2_a_reg[3] == p2_b_reg[3]);
            end
            default: begin
                m3.err = 1'b0;
            end
        endcase
    end

    // Square root pipeline: two radicand bits and one root bit per stage.
    logic                sq_vld_reg  [0:SQ_STEPS];
    meta_t               sq_meta_reg [0:SQ_STEPS];
    logic [SW-1:0]       sq_rad_reg  [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] sq_rem_reg  [0:SQ_STEPS];
    logic [RT_W-1:0]     sq_root_reg [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg[0] <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_meta_reg[0] <= m3;
            sq_rad_reg[0]  <= {1'b0, p2_sa_reg};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [SQ_REM_W+1:0] sq_r;
        logic [SQ_REM_W+1:0] sq_trial;
        logic                sq_ge;

        assign sq_r     = {sq_rem_reg[k], sq_rad_reg[k][SW-1:SW-2]};
        assign sq_trial = (SQ_REM_W+2)'({sq_root_reg[k], 2'b01});
        assign sq_ge    = (sq_r >= sq_trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_meta_reg[k+1] <= sq_meta_reg[k];
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][SW-3:0], 2'b00};
                sq_rem_reg[k+1]  <= sq_ge ? SQ_REM_W'(sq_r - sq_trial) : SQ_REM_W'(sq_r);
                sq_root_reg[k+1] <= {sq_root_reg[k][RT_W-2:0], sq_ge};
            end
        end
    end

    // Divider entry: pick the divisor and finish the length operation.
    logic [RT_W-1:0]  root;
    meta_t            dv_in_meta;
    logic [DEN_W-1:0] dv_in_den;
    logic             len_ovf;

    always_comb begin
        root       = sq_root_reg[SQ_STEPS];
        dv_in_meta = sq_meta_reg[SQ_STEPS];
        len_ovf    = root[RT_W-1] | root[RT_W-2];
        if (dv_in_meta.cmd == CMD_LEN) begin
            dv_in_meta.so  = len_ovf ? Q_MAX : root[QW-1:0];
            dv_in_meta.err = len_ovf;
        end
        if (dv_in_meta.cmd == CMD_NORMALIZE) begin
            dv_in_den = root;
        end else begin
            dv_in_den = {1'b0, dv_in_meta.den};
        end
    end

    // Quotient pipeline: one quotient bit per stage in each of the four lanes.
    logic             dv_vld_reg  [0:DV_W];
    meta_t            dv_meta_reg [0:DV_W];
    logic [DEN_W-1:0] dv_den_reg  [0:DV_W];
    logic [DV_W-1:0]  dv_sh_reg   [0:DV_W][LANES];
    logic [DEN_W-1:0] dv_rem_reg  [0:DV_W][LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_meta_reg[0] <= dv_in_meta;
            dv_den_reg[0]  <= dv_in_den;
            for (int i = 0; i < LANES; i++) begin
                dv_sh_reg[0][i]  <= {dv_in_meta.mag[i], {FRAC_BITS{1'b0}}};
                dv_rem_reg[0][i] <= '0;
            end
        end
    end

    for (genvar k = 0; k < DV_W; k++) begin : g_dv
        logic [DEN_W:0] dv_r  [LANES];
        logic           dv_ge [LANES];

        always_comb begin
            for (int i = 0; i < LANES; i++) begin
                dv_r[i]  = {dv_rem_reg[k][i], dv_sh_reg[k][i][DV_W-1]};
                dv_ge[i] = (dv_r[i] >= {1'b0, dv_den_reg[k]});
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_meta_reg[k+1] <= dv_meta_reg[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                for (int i = 0; i < LANES; i++) begin
                    dv_sh_reg[k+1][i]  <= {dv_sh_reg[k][i][DV_W-2:0], dv_ge[i]};
                    dv_rem_reg[k+1][i] <= dv_ge[i] ? DEN_W'(dv_r[i] - {1'b0, dv_den_reg[k]})
                                                   : DEN_W'(dv_r[i]);
                end
            end
        end
    end

    // Output stage: sign, saturation and divide-by-zero handling.
    meta_t            fin_meta;
    logic [DV_W-1:0]  fin_q    [LANES];
    logic [QW-1:0]    fin_r    [LANES];
    logic [LANES-1:0] fin_ovf;
    logic             fin_den0;
    logic [OUT_W-1:0] out_data_next;

    always_comb begin
        fin_meta = dv_meta_reg[DV_W];
        fin_den0 = (dv_den_reg[DV_W] == '0);
        for (int i = 0; i < LANES; i++) begin
            fin_q[i] = dv_sh_reg[DV_W][i];
            if (!fin_meta.use_div) begin
                fin_r[i]   = fin_meta.r[i];
                fin_ovf[i] = 1'b0;
            end else if (fin_den0) begin
                fin_ovf[i] = (fin_meta.mag[i] != '0);
                if (!fin_ovf[i]) begin
                    fin_r[i] = '0;
                end else begin
                    fin_r[i] = fin_meta.neg[i] ? Q_MIN : Q_MAX;
                end
            end else if (!fin_meta.neg[i]) begin
                fin_ovf[i] = |fin_q[i][DV_W-1:QW-1];
                fin_r[i]   = fin_ovf[i] ? Q_MAX : fin_q[i][QW-1:0];
            end else begin
                fin_ovf[i] = (|fin_q[i][DV_W-1:QW])
                          || (fin_q[i][QW-1] && (|fin_q[i][QW-2:0]));
                fin_r[i]   = fin_ovf[i] ? Q_MIN : (~fin_q[i][QW-1:0] + 1'b1);
            end
        end
        out_data_next = {{OUT_PAD{1'b0}}, fin_meta.err | (|fin_ovf), fin_meta.eq,
                         fin_meta.so, fin_r[3], fin_r[2], fin_r[1], fin_r[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld_reg[DV_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/core/qalu_chk.sv =====
// Port-level checker for quaternion_alu_unit, bound to every instance of it.
// Depends on qalu_pkg for the result payload layout.
module qalu_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [qalu_pkg::IN_W-1:0]    s_tdata,
    input logic [qalu_pkg::CMD_W-1:0]   s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [qalu_pkg::OUT_W-1:0]   m_tdata
);
    import qalu_pkg::*;

    // A result that waits keeps its value until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result stops new input, and an empty output never blocks it.
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the output is stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while the output is empty");

    // An equality hit carries no quaternion, scalar or error.
    a_equal_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[EQ_BIT] |-> !m_tdata[ERR_BIT] && (m_tdata[EQ_BIT-1:0] == '0))
        else $error("equality result with other fields set");

endmodule

bind quaternion_alu_unit qalu_chk u_qalu_chk (.*);
